/* design/cfr_pkg.sv */
package cfr_pkg;

  localparam int unsigned RING_SAMPLES = 4096;
  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned FRAME_SLOTS  = 8;
  localparam int unsigned SLOT_W       = 3;
  localparam int unsigned IDX_W        = $clog2(RING_SAMPLES);
  localparam int unsigned CNT_W        = $clog2(RING_SAMPLES + 1);
  localparam int unsigned CH_W         = 4;
  localparam int unsigned FILL_W       = 13;
  localparam int unsigned SAMPLE_W     = 32;
  localparam int unsigned QUEUE_DEPTH  = 2;

  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ
  } op_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
    logic [SAMPLE_W-1:0] sample_7;
  } cfr_in_t;

  typedef struct packed {
    logic                read_valid;
    logic [SAMPLE_W-1:0] read_sample;
    logic                frame_dropped;
    logic [FILL_W-1:0]   fill_level;
    logic [31:0]         dropped_total;
  } cfr_out_t;

  typedef struct packed {
    op_kind_e         kind;
    logic [CH_W-1:0]  ch;
    logic [IDX_W-1:0] addr;
    cfr_in_t          frame;
    cfr_out_t         res;
  } cfr_op_t;

endpackage

/* design/cfr_ram.sv */
module cfr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/cfr_queue.sv */
module cfr_queue import cfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cfr_op_t push_op_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output cfr_op_t pop_op_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cfr_op_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wptr_q, wptr_d;
  logic [PTR_W-1:0]    rptr_q, rptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o  = (cnt_q != '0);
  assign pop_op_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_op_i;
    end
  end

endmodule

/* design/cfr_front.sv */
module cfr_front import cfr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cfr_in_t         in_word_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CH_W-1:0] cfg_data_i,
  output logic            push_o,
  output cfr_op_t         push_op_o,
  input  logic            full_i
);

  logic [CH_W-1:0]  frame_channels_q;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [31:0]      drop_q, drop_d;

  logic [CH_W-1:0]  ch;
  logic [CNT_W-1:0] space;
  logic             fits;
  logic [IDX_W:0]   wsum;
  logic             accept;

  assign in_ready_o  = !full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !full_i;
  assign push_o      = accept;

  always_comb begin
    if (frame_channels_q == '0) begin
      ch = CH_W'(1);
    end else if (frame_channels_q > CH_W'(MAX_CHANNELS)) begin
      ch = CH_W'(MAX_CHANNELS);
    end else begin
      ch = frame_channels_q;
    end
    space = CNT_W'(RING_SAMPLES) - count_q;
    fits  = (CNT_W'(ch) <= space);
    wsum  = (IDX_W + 1)'(wr_idx_q) + (IDX_W + 1)'(ch);
    if (wsum >= (IDX_W + 1)'(RING_SAMPLES)) begin
      wsum = wsum - (IDX_W + 1)'(RING_SAMPLES);
    end
  end

  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    count_d  = count_q;
    drop_d   = drop_q;
    push_op_o.kind  = OP_NONE;
    push_op_o.ch    = ch;
    push_op_o.addr  = wr_idx_q;
    push_op_o.frame = in_word_i;
    push_op_o.res.read_valid    = 1'b0;
    push_op_o.res.read_sample   = '0;
    push_op_o.res.frame_dropped = 1'b0;
    if (in_word_i.cmd == CMD_WRITE) begin
      if (fits) begin
        push_op_o.kind = OP_WRITE;
        wr_idx_d = IDX_W'(wsum);
        count_d  = count_q + CNT_W'(ch);
      end else begin
        push_op_o.res.frame_dropped = 1'b1;
        if (drop_q != '1) begin
          drop_d = drop_q + 1'b1;
        end
      end
    end else begin
      push_op_o.addr = rd_idx_q;
      if (count_q != '0) begin
        push_op_o.kind = OP_READ;
        push_op_o.res.read_valid = 1'b1;
        rd_idx_d = (rd_idx_q == IDX_W'(RING_SAMPLES - 1)) ? '0 : rd_idx_q + 1'b1;
        count_d  = count_q - 1'b1;
      end
    end
    push_op_o.res.fill_level    = FILL_W'(count_d);
    push_op_o.res.dropped_total = drop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_channels_q <= CH_W'(1);
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      count_q  <= '0;
      drop_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        frame_channels_q <= cfg_data_i;
      end
      if (accept) begin
        wr_idx_q <= wr_idx_d;
        rd_idx_q <= rd_idx_d;
        count_q  <= count_d;
        drop_q   <= drop_d;
      end
    end
  end

endmodule

/* design/cfr_back.sv */
module cfr_back import cfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  cfr_op_t  q_op_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cfr_out_t out_word_o
);

  back_state_e state_q, state_d;
  cfr_op_t     job_q;
  logic [IDX_W-1:0]    addr_q, addr_d;
  logic [SLOT_W-1:0]   k_q, k_d;
  logic                out_valid_q, out_valid_d;
  cfr_out_t            out_word_q, out_word_d;

  logic                we;
  logic                re;
  logic                out_free;
  logic                last_slot;
  logic [SAMPLE_W-1:0] wdata;
  logic [SAMPLE_W-1:0] rdata;

  cfr_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(RING_SAMPLES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(addr_q),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(job_q.addr),
    .rdata_o(rdata)
  );

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_slot = (k_q == SLOT_W'(job_q.ch - 1'b1));

  always_comb begin
    case (k_q)
      3'd0: wdata = job_q.frame.sample_0;
      3'd1: wdata = job_q.frame.sample_1;
      3'd2: wdata = job_q.frame.sample_2;
      3'd3: wdata = job_q.frame.sample_3;
      3'd4: wdata = job_q.frame.sample_4;
      3'd5: wdata = job_q.frame.sample_5;
      3'd6: wdata = job_q.frame.sample_6;
      3'd7: wdata = job_q.frame.sample_7;
      default: wdata = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_op_i.kind)
            OP_WRITE: state_d = ST_WRITE;
            OP_READ:  state_d = ST_READ;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_WRITE: begin
        if (last_slot) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    addr_d      = addr_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    case (state_q)
      ST_IDLE: begin
        pop_o  = q_valid_i;
        addr_d = q_op_i.addr;
        k_d    = '0;
      end
      ST_WRITE: begin
        we     = 1'b1;
        k_d    = k_q + 1'b1;
        addr_d = (addr_q == IDX_W'(RING_SAMPLES - 1)) ? '0 : addr_q + 1'b1;
      end
      ST_READ: begin
        re = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = job_q.res;
          out_word_d.read_sample = (job_q.kind == OP_READ) ? rdata : '0;
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= q_op_i;
    end
    addr_q     <= addr_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* design/capture_frame_ring_with_drop_count_core.sv */
// Audio capture sample ring with whole-frame drop and a saturating drop count.
// Input channel (in_valid_i/in_ready_o/in_word_i): cmd 0 writes one frame of
// frame_channels samples (clamped to 1..8), cmd 1 pops one stored sample.
// Output channel (out_valid_o/out_ready_i/out_word_o): exactly one word per
// input word, in order, carrying the pop result, drop flag, fill level and
// drop total after that item.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_data_i): sets frame_channels;
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. The front classifies each word and
// updates the indices, fill count and drop count in the cycle it is accepted,
// then queues the job (2 entries) for the back, which stores a frame one
// sample per cycle into a single-port-write RAM and does reads with a
// registered RAM read. The back takes one job at a time from the queue while
// idle, then writes the frame or issues the read, and loads the output
// register in its done state; a dropped frame or an empty pop goes straight
// to done. If the receiver stalls the output register holds, the back waits,
// the queue fills and in_ready_o falls. Reset empties the ring, zeroes the
// drop count and sets frame_channels to 1; no RAM clearing pass is needed.
module capture_frame_ring_with_drop_count_core import cfr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cfr_in_t         in_word_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cfr_out_t        out_word_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CH_W-1:0] cfg_data_i
);

  logic    push;
  cfr_op_t push_op;
  logic    full;
  logic    pop;
  logic    q_valid;
  cfr_op_t q_op;

  cfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .push_o     (push),
    .push_op_o  (push_op),
    .full_i     (full)
  );

  cfr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .push_op_i(push_op),
    .full_o   (full),
    .pop_i    (pop),
    .valid_o  (q_valid),
    .pop_op_o (q_op)
  );

  cfr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_op_i     (q_op),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

endmodule

/* tb/tb_capture_frame_ring_with_drop_count_core.sv */
module tb_capture_frame_ring_with_drop_count_core import cfr_pkg::*; ();

  class ring_scoreboard;
    logic [SAMPLE_W-1:0] store [RING_SAMPLES];
    logic [IDX_W-1:0]    wr_idx;
    logic [IDX_W-1:0]    rd_idx;
    logic [CNT_W-1:0]    level;
    logic [31:0]         drops;
    logic [CH_W-1:0]     chan_reg;
    cfr_out_t            expected_q[$];
    int                  errors;

    function new();
      wr_idx   = '0;
      rd_idx   = '0;
      level    = '0;
      drops    = '0;
      chan_reg = 4'd1;
      errors   = 0;
    endfunction

    function void set_channels(logic [CH_W-1:0] v);
      chan_reg = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(cfr_in_t w);
      cfr_out_t            r;
      int unsigned         ch;
      logic [SAMPLE_W-1:0] smp [FRAME_SLOTS];
      r   = '0;
      smp = '{w.sample_0, w.sample_1, w.sample_2, w.sample_3,
              w.sample_4, w.sample_5, w.sample_6, w.sample_7};
      if (w.cmd == CMD_WRITE) begin
        if (chan_reg == 0) ch = 1;
        else if (chan_reg > MAX_CHANNELS) ch = MAX_CHANNELS;
        else ch = 32'(chan_reg);
        if (ch <= RING_SAMPLES - level) begin
          for (int k = 0; k < ch; k++) begin
            store[wr_idx] = smp[k];
            wr_idx = (wr_idx == RING_SAMPLES - 1) ? '0 : wr_idx + 1'b1;
          end
          level = level + CNT_W'(ch);
        end else begin
          r.frame_dropped = 1'b1;
          if (drops != '1) drops = drops + 1'b1;
        end
      end else if (level != 0) begin
        r.read_valid  = 1'b1;
        r.read_sample = store[rd_idx];
        rd_idx = (rd_idx == RING_SAMPLES - 1) ? '0 : rd_idx + 1'b1;
        level  = level - 1'b1;
      end
      r.fill_level    = level;
      r.dropped_total = drops;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(cfr_out_t got);
      cfr_out_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("read_valid", want.read_valid, got.read_valid);
      compare_field("read_sample", want.read_sample, got.read_sample);
      compare_field("frame_dropped", want.frame_dropped, got.frame_dropped);
      compare_field("fill_level", want.fill_level, got.fill_level);
      compare_field("dropped_total", want.dropped_total, got.dropped_total);
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  cfr_in_t         in_word_i;
  logic            out_valid_o;
  logic            out_ready_i;
  cfr_out_t        out_word_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [CH_W-1:0] cfg_data_i;

  ring_scoreboard sb = new();

  capture_frame_ring_with_drop_count_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic cfr_in_t rand_word(int read_pct);
    cfr_in_t w;
    w.cmd      = ($urandom_range(0, 99) < read_pct) ? CMD_READ : CMD_WRITE;
    w.sample_0 = pick_sample();
    w.sample_1 = pick_sample();
    w.sample_2 = pick_sample();
    w.sample_3 = pick_sample();
    w.sample_4 = pick_sample();
    w.sample_5 = pick_sample();
    w.sample_6 = pick_sample();
    w.sample_7 = pick_sample();
    return w;
  endfunction

  function automatic cfr_in_t make_word(cmd_e cmd, logic [31:0] seed);
    cfr_in_t w;
    w.cmd      = cmd;
    w.sample_0 = seed;
    w.sample_1 = seed + 32'h0101_0101;
    w.sample_2 = seed + 32'h0202_0202;
    w.sample_3 = seed + 32'h0303_0303;
    w.sample_4 = seed + 32'h0404_0404;
    w.sample_5 = seed + 32'h0505_0505;
    w.sample_6 = seed + 32'h0606_0606;
    w.sample_7 = seed + 32'h0707_0707;
    return w;
  endfunction

  task automatic send_word(input cfr_in_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(w);
  endtask

  // hold the sender until every result is back, then let the back drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_channels(input logic [CH_W-1:0] v);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_channels(v);
  endtask

  task automatic run_random(input int n, input int read_pct);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && sent < n; i++) begin
        send_word(rand_word(read_pct));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    int  hold;
    logic rdy;
    hold = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_word_o);
      if (hold > 0) begin
        hold--;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            rdy  = 1'b0;
            hold = $urandom_range(2, 20);
          end
          1, 2, 3: begin
            rdy  = 1'b1;
            hold = $urandom_range(10, 60);
          end
          default: begin
            rdy  = 1'($urandom_range(0, 1));
            hold = 0;
          end
        endcase
        out_ready_i <= rdy;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pops, clamp of channel count, unused samples
    send_word(make_word(CMD_READ, 32'h0));
    send_word(make_word(CMD_WRITE, 32'hFFFF_FFFF));
    send_word(make_word(CMD_WRITE, 32'h0));
    send_word(make_word(CMD_READ, 32'h0));
    send_word(make_word(CMD_READ, 32'hFFFF_FFFF));
    send_word(make_word(CMD_READ, 32'h0));
    write_channels(4'd0);
    send_word(make_word(CMD_WRITE, 32'h1234_5678));
    send_word(make_word(CMD_READ, 32'h0));
    write_channels(4'd15);
    send_word(make_word(CMD_WRITE, 32'hA5A5_A5A5));
    send_word(make_word(CMD_READ, 32'h0));
    send_word(make_word(CMD_READ, 32'h0));
    write_channels(4'd9);
    send_word(make_word(CMD_WRITE, 32'h5A5A_5A5A));
    write_channels(4'd3);
    send_word(make_word(CMD_WRITE, 32'hDEAD_BEEF));
    send_word(make_word(CMD_READ, 32'h0));
    write_channels(4'd7);
    send_word(make_word(CMD_WRITE, 32'h0F0F_0F0F));

    // fill past full: drops, write index wraps mid-frame
    write_channels(4'd8);
    run_random(560, 5);
    write_channels(4'd2);
    run_random(150, 50);
    // drain part of the ring
    write_channels(4'd1);
    run_random(150, 98);
    write_channels(4'd4);
    run_random(100, 45);
    write_channels(4'd0);
    run_random(50, 50);
    write_channels(4'd12);
    run_random(50, 50);
    write_channels(4'd6);
    run_random(50, 55);

    settle();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[capture_frame_ring_with_drop_count_core] OK");
    end else begin
      $display("[capture_frame_ring_with_drop_count_core] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[capture_frame_ring_with_drop_count_core] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
design/cfr_pkg.sv
design/cfr_ram.sv
design/cfr_queue.sv
design/cfr_front.sv
design/cfr_back.sv
design/capture_frame_ring_with_drop_count_core.sv
tb/tb_capture_frame_ring_with_drop_count_core.sv
